// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/fsnd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsnd_pkg
// Shared constants, types and segment code tables of the flip-segment driver.
// ----------------------------------------------------------------------------
`default_nettype none

package fsnd_pkg;

	localparam int DIGIT_COUNT = 6;
	localparam int COUNT_W     = 20;
	localparam int IDX_W       = 3;
	localparam int DIGIT_W     = 4;
	localparam int CODE_W      = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 20'd999999;
	localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 4'd10;
	localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(DIGIT_COUNT - 1);

	// reciprocal of ten, scaled by 2^23; exact quotient for any 20-bit value
	localparam logic [23:0] RECIP10     = 24'hCCCCD;
	localparam int          RECIP_SHIFT = 23;

	typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] digit_vec_t;

	typedef struct packed {
		logic       start;
		digit_vec_t digits;
	} pulse_req_t;

	typedef struct packed {
		logic [2:0] position;
		logic       polarity;
		logic [7:0] common_a;
		logic [7:0] common_b;
		logic       port;
		logic [7:0] bits;
		logic       last;
	} pulse_t;

	function automatic logic [CODE_W-1:0] white_code(input logic [DIGIT_W-1:0] d);
		logic [CODE_W-1:0] c;
		case (d)
			4'd0:    c = 16'hF030;
			4'd1:    c = 16'h6000;
			4'd2:    c = 16'hB050;
			4'd3:    c = 16'hF040;
			4'd4:    c = 16'h6060;
			4'd5:    c = 16'hD060;
			4'd6:    c = 16'hD070;
			4'd7:    c = 16'h7000;
			4'd8:    c = 16'hF070;
			4'd9:    c = 16'hF060;
			default: c = 16'h0000;
		endcase
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] black_code(input logic [DIGIT_W-1:0] d);
		logic [CODE_W-1:0] c;
		case (d)
			4'd0:    c = 16'h0004;
			4'd1:    c = 16'h0907;
			4'd2:    c = 16'h0402;
			4'd3:    c = 16'h0003;
			4'd4:    c = 16'h0901;
			4'd5:    c = 16'h0201;
			4'd6:    c = 16'h0200;
			4'd7:    c = 16'h0807;
			4'd8:    c = 16'h0000;
			4'd9:    c = 16'h0001;
			default: c = 16'h0F07;
		endcase
		return c;
	endfunction

	// positions 1..4 drive common register A, 5..8 drive common register B
	function automatic logic [7:0] common_a(input logic [IDX_W-1:0] idx, input logic pol);
		logic [7:0] base;
		base = pol ? 8'h01 : 8'h10;
		return (idx < IDX_W'(4)) ? (base << idx[1:0]) : 8'h00;
	endfunction

	function automatic logic [7:0] common_b(input logic [IDX_W-1:0] idx, input logic pol);
		logic [7:0] base;
		base = pol ? 8'h01 : 8'h10;
		return (idx >= IDX_W'(4)) ? (base << idx[1:0]) : 8'h00;
	endfunction

endpackage

`default_nettype wire

// ----- design/fsnd_div10.sv -----
// ----------------------------------------------------------------------------
// fsnd_div10
// Divide-by-ten unit: quotient by reciprocal multiply, remainder by back-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnd_div10 (
	input  wire logic [fsnd_pkg::COUNT_W-1:0] num,
	output logic      [fsnd_pkg::COUNT_W-1:0] quo,
	output logic      [fsnd_pkg::DIGIT_W-1:0] rem
);

	logic [43:0] prod;
	logic [23:0] quo10;
	logic [23:0] diff;

	assign prod  = {24'd0, num} * {20'd0, fsnd_pkg::RECIP10};
	assign quo   = prod[fsnd_pkg::RECIP_SHIFT +: fsnd_pkg::COUNT_W];
	assign quo10 = {1'b0, quo, 3'b000} + {3'b000, quo, 1'b0};
	assign diff  = {4'd0, num} - quo10;
	assign rem   = diff[fsnd_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

// ----- design/fsnd_pulse_gen.sv -----
// ----------------------------------------------------------------------------
// fsnd_pulse_gen
// Walks positions and phases, emits one transfer per set segment code bit.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnd_pulse_gen (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fsnd_pkg::pulse_req_t req,
	output logic                      busy,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output fsnd_pkg::pulse_t          out_pulse
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_LOAD = 2'd1;
	localparam logic [1:0] P_EMIT = 2'd2;

	logic [1:0]                          state_q;
	logic [fsnd_pkg::IDX_W-1:0]          pos_q;
	logic                                pol_q;
	logic [fsnd_pkg::CODE_W-1:0]         mask_q;
	logic                                out_valid_q;
	fsnd_pkg::pulse_t                    out_q;

	logic [fsnd_pkg::DIGIT_W-1:0]        cur_digit;
	logic [fsnd_pkg::CODE_W-1:0]         cur_code;
	logic [fsnd_pkg::CODE_W-1:0]         lsb;
	logic [fsnd_pkg::CODE_W-1:0]         rest;
	logic                                has_white;
	logic                                final_phase;
	logic                                slot_free;
	logic                                fire;
	logic                                advance;

	assign cur_digit   = req.digits[pos_q];
	assign cur_code    = pol_q ? fsnd_pkg::white_code(cur_digit)
	                           : fsnd_pkg::black_code(cur_digit);
	assign has_white   = (cur_digit != fsnd_pkg::BLANK_DIGIT);
	assign final_phase = (pos_q == fsnd_pkg::LAST_IDX) && (pol_q || !has_white);

	// lowest set bit first; mask holds the high code byte in its low half
	assign lsb  = mask_q & (~mask_q + fsnd_pkg::CODE_W'(1));
	assign rest = mask_q & (mask_q - fsnd_pkg::CODE_W'(1));

	assign slot_free = !out_valid_q || out_ready;
	assign fire      = (state_q == P_EMIT) && (mask_q != '0) && slot_free;
	assign advance   = (state_q == P_EMIT) && ((mask_q == '0) || (fire && rest == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			pos_q   <= '0;
			pol_q   <= 1'b0;
		end else begin
			case (state_q)
				P_IDLE: begin
					if (req.start) begin
						pos_q   <= '0;
						pol_q   <= 1'b0;
						state_q <= P_LOAD;
					end
				end
				P_LOAD: begin
					state_q <= P_EMIT;
				end
				P_EMIT: begin
					if (advance) begin
						if (!pol_q && has_white) begin
							pol_q   <= 1'b1;
							state_q <= P_LOAD;
						end else if (pos_q == fsnd_pkg::LAST_IDX) begin
							state_q <= P_IDLE;
						end else begin
							pos_q   <= pos_q + fsnd_pkg::IDX_W'(1);
							pol_q   <= 1'b0;
							state_q <= P_LOAD;
						end
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == P_LOAD) begin
			mask_q <= {cur_code[7:0], cur_code[15:8]};
		end else if (fire) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.position <= pos_q + 3'd1;
			out_q.polarity <= pol_q;
			out_q.common_a <= fsnd_pkg::common_a(pos_q, pol_q);
			out_q.common_b <= fsnd_pkg::common_b(pos_q, pol_q);
			out_q.port     <= (lsb[15:8] != 8'h00);
			out_q.bits     <= lsb[7:0] | lsb[15:8];
			out_q.last     <= final_phase && (rest == '0);
		end
	end

	assign busy      = (state_q != P_IDLE);
	assign out_valid = out_valid_q;
	assign out_pulse = out_q;

endmodule

`default_nettype wire

// ----- design/flip_segment_number_driver_top.sv -----
// ----------------------------------------------------------------------------
// flip_segment_number_driver_top
// Turns a count into the segment pulse list for a six-digit flip display.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one count per transfer (s_tdata[19:0]). Counts above
//   999999 saturate. A count equal to the one shown last produces nothing.
//   m_* channel gives one transfer per segment pulse, 42 per new count,
//   leftmost position first, black phase then white; tlast marks the final
//   pulse of a count.
//   Decimal conversion yields one digit per cycle through the shared
//   divide-by-ten unit, and a handoff register then starts the pulse
//   generator, which passes through a load state for each code phase and
//   then emits the phase's pulses (a black phase with no segments leaves
//   its emit state without a pulse). s_tready stays low while a count is
//   being converted or its pulses are being generated.
//   The pulse output is registered; when m_tready is low the generator holds
//   its position and resumes as soon as the held transfer is taken.
//   Reset clears the shown count to zero, so a first count of zero emits
//   nothing, and drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flip_segment_number_driver_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [19:0] count_value, [23:20] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [2:0] digit_position, [10:3] common_a_byte,
	                                    // [18:11] common_b_byte, [26:19] segment_bits,
	                                    // [31:27] zero
	output logic [1:0]       m_tuser,   // [0] polarity, [1] segment_port
	output logic             m_tlast
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_CONV = 1'b1;

	logic                             state_q;
	logic [fsnd_pkg::COUNT_W-1:0]     shown_q;
	logic [fsnd_pkg::COUNT_W-1:0]     work_q;
	logic [fsnd_pkg::IDX_W-1:0]       k_q;
	fsnd_pkg::digit_vec_t             digit_q;
	logic                             start_q;

	logic [fsnd_pkg::COUNT_W-1:0]     sat_count;
	logic [fsnd_pkg::COUNT_W-1:0]     div_quo;
	logic [fsnd_pkg::DIGIT_W-1:0]     div_rem;
	logic                             in_fire;
	logic                             blank;
	logic                             gen_busy;
	fsnd_pkg::pulse_req_t             req;
	fsnd_pkg::pulse_t                 pulse;

	assign sat_count = (s_tdata[19:0] > fsnd_pkg::COUNT_MAX) ? fsnd_pkg::COUNT_MAX
	                                                         : s_tdata[19:0];
	assign s_tready  = (state_q == S_IDLE) && !gen_busy && !start_q;
	assign in_fire   = s_tvalid && s_tready;
	assign blank     = (work_q == '0) && (k_q != fsnd_pkg::LAST_IDX);

	fsnd_div10 u_div10 (
		.num (work_q),
		.quo (div_quo),
		.rem (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			shown_q <= '0;
			start_q <= 1'b0;
			k_q     <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire && sat_count != shown_q) begin
						shown_q <= sat_count;
						k_q     <= fsnd_pkg::LAST_IDX;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (k_q == '0) begin
						start_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q - fsnd_pkg::IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// rightmost digit first; leading zeros become blanks
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire) begin
			work_q <= sat_count;
		end else if (state_q == S_CONV) begin
			work_q        <= div_quo;
			digit_q[k_q]  <= blank ? fsnd_pkg::BLANK_DIGIT : div_rem;
		end
	end

	assign req.start  = start_q;
	assign req.digits = digit_q;

	fsnd_pulse_gen u_pulse_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (gen_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pulse (pulse)
	);

	assign m_tdata = {5'd0, pulse.bits, pulse.common_b, pulse.common_a, pulse.position};
	assign m_tuser = {pulse.port, pulse.polarity};
	assign m_tlast = pulse.last;

	`ASSERT_IMPL(a_rem_digit, clk, arst_n, state_q == S_CONV, div_rem < 4'd10)
	`ASSERT_NEXT(a_shown_hold, clk, arst_n, !in_fire, $stable(shown_q))
	`ASSERT_IMPL(a_pos_nonzero, clk, arst_n, m_tvalid, m_tdata[2:0] != 3'd0)
	`ASSERT_IMPL(a_onehot_bits, clk, arst_n, m_tvalid, $onehot(m_tdata[26:19]))

endmodule

`default_nettype wire
